/* rtl/nds_pkg.sv */
// Shared constants and types for the nearest direction search block.
`default_nettype none
package nds_pkg;

	localparam int ENTRIES   = 512;
	localparam int ADDR_W    = $clog2(ENTRIES);
	localparam int COMP_W    = 16;
	localparam int VEC_W     = 3 * COMP_W;
	localparam int MAG_W     = COMP_W;
	localparam int SQ_W      = 2 * MAG_W;
	localparam int DIST_W    = SQ_W + 2;
	localparam int OUT_IDX_W = 9;
	localparam int OUT_DST_W = 32;
	localparam int SLOT_W    = 9;
	localparam int CFG_W     = 10;

	localparam logic [CFG_W-1:0] CFG_RESET = 10'd400;

	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_SCAN,
		SEQ_DRAIN
	} seq_state_t;

	typedef struct packed {
		logic signed [COMP_W-1:0] x;
		logic signed [COMP_W-1:0] y;
		logic signed [COMP_W-1:0] z;
	} vec3_t;

	// travels with each table read down the distance pipeline
	typedef struct packed {
		logic              valid;
		logic              first;
		logic              last;
		logic [ADDR_W-1:0] idx;
	} scan_tag_t;

endpackage
`default_nettype wire

/* rtl/nds_ram.sv */
// Simple dual-port RAM, one write and one registered read port.
`default_nettype none
module nds_ram #(
	parameter int DEPTH = 512,
	parameter int WIDTH = 48,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

/* rtl/nds_seq.sv */
// Command decode, scan length register and table address sequencer.
`default_nettype none
module nds_seq
	import nds_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [CFG_W-1:0]  cfg_wdata,
	input  wire logic              start,
	input  wire logic              mode,
	input  wire logic [SLOT_W-1:0] entry_index,
	input  wire vec3_t             vec_in,
	input  wire logic              result_done,
	output logic                   busy,
	output logic                   wr_en,
	output logic [ADDR_W-1:0]      wr_addr,
	output logic [VEC_W-1:0]       wr_data,
	output logic                   rd_en,
	output logic [ADDR_W-1:0]      rd_addr,
	output scan_tag_t              tag,
	output vec3_t                  query
);

	seq_state_t        state_q, state_d;
	logic [CFG_W-1:0]  entries_used_q;
	logic [ADDR_W-1:0] addr_q;
	logic [ADDR_W-1:0] last_q;
	vec3_t             query_q;
	logic              accept;
	logic              at_last;

	assign accept  = start && !busy;
	assign at_last = (addr_q == last_q);

	assign wr_en   = accept && (mode == MODE_WRITE) && (32'(entry_index) < ENTRIES);
	assign wr_addr = ADDR_W'(entry_index);
	assign wr_data = {vec_in.z, vec_in.y, vec_in.x};
	assign rd_addr = addr_q;
	assign query   = query_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_used_q <= CFG_RESET;
		end else if (cfg_we) begin
			entries_used_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// clamp the scan length into 1 .. ENTRIES at the query transfer
	always_ff @(posedge clk) begin
		if (accept && (mode == MODE_QUERY)) begin
			query_q <= vec_in;
			addr_q  <= '0;
			if (entries_used_q == '0) begin
				last_q <= '0;
			end else if (32'(entries_used_q) > ENTRIES) begin
				last_q <= ADDR_W'(ENTRIES - 1);
			end else begin
				last_q <= ADDR_W'(32'(entries_used_q) - 32'd1);
			end
		end else if (state_q == SEQ_SCAN) begin
			addr_q <= addr_q + 1'b1;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			SEQ_IDLE: begin
				if (accept && (mode == MODE_QUERY)) begin
					state_d = SEQ_SCAN;
				end
			end
			SEQ_SCAN: begin
				if (at_last) begin
					state_d = SEQ_DRAIN;
				end
			end
			SEQ_DRAIN: begin
				if (result_done) begin
					state_d = SEQ_IDLE;
				end
			end
			default: state_d = SEQ_IDLE;
		endcase
	end

	always_comb begin
		busy      = 1'b1;
		rd_en     = 1'b0;
		tag.valid = 1'b0;
		tag.first = 1'b0;
		tag.last  = 1'b0;
		tag.idx   = addr_q;
		unique case (state_q)
			SEQ_IDLE: begin
				busy = 1'b0;
			end
			SEQ_SCAN: begin
				rd_en     = 1'b1;
				tag.valid = 1'b1;
				tag.first = (addr_q == '0);
				tag.last  = at_last;
			end
			SEQ_DRAIN: begin
				busy = 1'b1;
			end
			default: busy = 1'b1;
		endcase
	end

endmodule
`default_nettype wire

/* rtl/nds_dist.sv */
// Squared distance pipeline: component differences, squares, sum.
`default_nettype none
module nds_dist
	import nds_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire scan_tag_t        tag_in,
	input  wire vec3_t            query,
	input  wire logic [VEC_W-1:0] rd_data,
	output scan_tag_t             tag_s3,
	output logic [DIST_W-1:0]     dist_s3
);

	scan_tag_t        tag_s1, tag_s2;
	logic [SQ_W-1:0]  sq_x_s2, sq_y_s2, sq_z_s2;
	logic [MAG_W-1:0] mag_x, mag_y, mag_z;

	function automatic logic [MAG_W-1:0] abs_diff(
		input logic [COMP_W-1:0] a,
		input logic [COMP_W-1:0] b
	);
		logic signed [COMP_W:0] d;
		logic signed [COMP_W:0] n;
		d = signed'({a[COMP_W-1], a}) - signed'({b[COMP_W-1], b});
		n = -d;
		abs_diff = d[COMP_W] ? n[MAG_W-1:0] : d[MAG_W-1:0];
	endfunction

	assign mag_x = abs_diff(rd_data[COMP_W-1:0], query.x);
	assign mag_y = abs_diff(rd_data[2*COMP_W-1:COMP_W], query.y);
	assign mag_z = abs_diff(rd_data[3*COMP_W-1:2*COMP_W], query.z);

	// tag_s1 lines up with the registered table read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
		end else begin
			tag_s1 <= tag_in;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
		end
	end

	always_ff @(posedge clk) begin
		sq_x_s2 <= mag_x * mag_x;
		sq_y_s2 <= mag_y * mag_y;
		sq_z_s2 <= mag_z * mag_z;
		dist_s3 <= DIST_W'(sq_x_s2) + DIST_W'(sq_y_s2) + DIST_W'(sq_z_s2);
	end

endmodule
`default_nettype wire

/* rtl/nds_best.sv */
// Running minimum over the scan and result register.
`default_nettype none
module nds_best
	import nds_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire scan_tag_t         tag_s3,
	input  wire logic [DIST_W-1:0] dist_s3,
	output logic                   done,
	output logic [OUT_IDX_W-1:0]   nearest_index,
	output logic [OUT_DST_W-1:0]   best_distance_sq
);

	logic [DIST_W-1:0] best_q, best_d;
	logic [ADDR_W-1:0] best_idx_q, best_idx_d;
	logic              take;

	// strictly smaller only, so ties keep the lower index
	assign take       = tag_s3.first || (dist_s3 < best_q);
	assign best_d     = take ? dist_s3 : best_q;
	assign best_idx_d = take ? tag_s3.idx : best_idx_q;

	always_ff @(posedge clk) begin
		if (tag_s3.valid) begin
			best_q     <= best_d;
			best_idx_q <= best_idx_d;
		end
		if (tag_s3.valid && tag_s3.last) begin
			nearest_index    <= OUT_IDX_W'(best_idx_d);
			best_distance_sq <= (|best_d[DIST_W-1:OUT_DST_W]) ? '1 : best_d[OUT_DST_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= tag_s3.valid && tag_s3.last;
		end
	end

endmodule
`default_nettype wire

/* rtl/nearest_direction_search.sv */
// Write: the table RAM write port takes the entry at the transfer; a new command may follow in the next cycle.
// Query: the scan reads N = clamped entries_used entries, then done strobes the result;
// busy is held until done, so the next command waits; entries use the one RAM read port.
// The result is shown for one cycle on done; the receiver cannot stall it.
// Reset clears control state and sets entries_used to 400; table is undefined until written.
`default_nettype none
module nearest_direction_search
	import nds_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [CFG_W-1:0]    cfg_wdata,
	input  wire logic                start,
	output logic                     busy,
	input  wire logic                mode,
	input  wire logic [SLOT_W-1:0]   entry_index,
	input  wire logic signed [15:0]  vec_x,
	input  wire logic signed [15:0]  vec_y,
	input  wire logic signed [15:0]  vec_z,
	output logic                     done,
	output logic [OUT_IDX_W-1:0]     nearest_index,
	output logic [OUT_DST_W-1:0]     best_distance_sq
);

	vec3_t             vec_in;
	vec3_t             query;
	scan_tag_t         tag, tag_s3;
	logic              wr_en, rd_en;
	logic [ADDR_W-1:0] wr_addr, rd_addr;
	logic [VEC_W-1:0]  wr_data, rd_data;
	logic [DIST_W-1:0] dist_s3;

	assign vec_in.x = vec_x;
	assign vec_in.y = vec_y;
	assign vec_in.z = vec_z;

	nds_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.start       (start),
		.mode        (mode),
		.entry_index (entry_index),
		.vec_in      (vec_in),
		.result_done (done),
		.busy        (busy),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr),
		.tag         (tag),
		.query       (query)
	);

	nds_ram #(
		.DEPTH (ENTRIES),
		.WIDTH (VEC_W)
	) u_table (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	nds_dist u_dist (
		.clk     (clk),
		.arst_n  (arst_n),
		.tag_in  (tag),
		.query   (query),
		.rd_data (rd_data),
		.tag_s3  (tag_s3),
		.dist_s3 (dist_s3)
	);

	nds_best u_best (
		.clk              (clk),
		.arst_n           (arst_n),
		.tag_s3           (tag_s3),
		.dist_s3          (dist_s3),
		.done             (done),
		.nearest_index    (nearest_index),
		.best_distance_sq (best_distance_sq)
	);

endmodule
`default_nettype wire
